FILE: rtl/core/status_led_mode_breather_defines.svh
// ----------------------------------------------------------------------------
// Status LED mode breather - assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STATUS_LED_MODE_BREATHER_DEFINES_SVH
`define STATUS_LED_MODE_BREATHER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SLMB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define SLMB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define SLMB_ASSERT_IMPL(label, ante, cons)
`define SLMB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/core/slmb_pkg.sv
// ----------------------------------------------------------------------------
// slmb_pkg
// Shared constants, types and lookup functions of the status LED breather.
// ----------------------------------------------------------------------------
package slmb_pkg;

    localparam int WAVE_STEPS_DEF = 16;

    localparam int PHASE_W     = 21;
    localparam int PERIOD_W    = 16;
    localparam int LEVEL_W     = 8;
    localparam int MODE_W      = 3;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    localparam logic [PHASE_W-1:0] PHASE_WRAP = 21'd1000000;

    // register reset values
    localparam logic [LEVEL_W-1:0]  RATE_LIMIT_RST  = 8'd90;
    localparam logic [LEVEL_W-1:0]  BUSY_THR_RST    = 8'd3;
    localparam logic [LEVEL_W-1:0]  ACT_MIN_RST     = 8'd40;
    localparam logic [LEVEL_W-1:0]  ACT_MAX_RST     = 8'd255;
    localparam logic [PERIOD_W-1:0] BREATHE_PER_RST = 16'd4000;
    localparam logic [PERIOD_W-1:0] PULSE_PER_RST   = 16'd1000;

    // fixed busy amber
    localparam logic [LEVEL_W-1:0] BUSY_RED   = 8'd255;
    localparam logic [LEVEL_W-1:0] BUSY_GREEN = 8'd100;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF    = 3'd0,
        MODE_IDLE   = 3'd1,
        MODE_ACTIVE = 3'd2,
        MODE_BUSY   = 3'd3,
        MODE_RATE   = 3'd4
    } mode_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RATE_LIMIT  = 3'd0,
        REG_BUSY_THR    = 3'd1,
        REG_ACT_MIN     = 3'd2,
        REG_ACT_MAX     = 3'd3,
        REG_BREATHE_PER = 3'd4,
        REG_PULSE_PER   = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic take;       // latch request, pick mode, advance phase
        logic div_start;  // load divider operands
        logic mul_en;     // register active-mode product
        logic out_load;   // load result register
    } slmb_cmd_t;

    function automatic logic [LEVEL_W-1:0] sine_level(input logic [3:0] t);
        logic [LEVEL_W-1:0] lvl;
        case (t)
            4'd0:    lvl = 8'd0;
            4'd1:    lvl = 8'd25;
            4'd2:    lvl = 8'd71;
            4'd3:    lvl = 8'd128;
            4'd4:    lvl = 8'd185;
            4'd5:    lvl = 8'd231;
            4'd6:    lvl = 8'd255;
            4'd7:    lvl = 8'd255;
            4'd8:    lvl = 8'd231;
            4'd9:    lvl = 8'd185;
            4'd10:   lvl = 8'd128;
            4'd11:   lvl = 8'd71;
            4'd12:   lvl = 8'd25;
            default: lvl = 8'd0;
        endcase
        return lvl;
    endfunction

    // x/3 for 8-bit x: x*171 >> 9 is exact over the whole range
    function automatic logic [LEVEL_W-1:0] div3(input logic [LEVEL_W-1:0] x);
        logic [16:0] prod;
        prod = 17'(x) * 17'd171;
        return prod[16:9];
    endfunction

endpackage

FILE: rtl/core/slmb_div.sv
// ----------------------------------------------------------------------------
// slmb_div
// Restoring divider, one quotient bit per cycle. Keeps the low quotient bits
// and the quotient modulo MOD_N, built up bit by bit.
// ----------------------------------------------------------------------------
module slmb_div #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 16,
    parameter int Q_W   = 8,
    parameter int MOD_N = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [NUM_W-1:0]           num,
    input  logic [DEN_W-1:0]           den,
    output logic                       done,
    output logic [Q_W-1:0]             quo,
    output logic [$clog2(MOD_N)-1:0]   quo_mod
);

    localparam int MOD_W = $clog2(MOD_N);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic [MOD_W-1:0] mod_reg, mod_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;
    logic [MOD_W:0]   mod_sh;
    logic [MOD_W-1:0] mod_step;

    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[NUM_W-1]};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_sub  = rem_sh - {1'b0, den_reg};
        mod_sh   = {mod_reg, ge};
        // 2*m+1 < 2*MOD_N, so one subtract brings it back in range
        if (mod_sh >= (MOD_W+1)'(MOD_N))
        begin
            mod_step = MOD_W'(mod_sh - (MOD_W+1)'(MOD_N));
        end
        else
        begin
            mod_step = mod_sh[MOD_W-1:0];
        end
    end

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        mod_next  = mod_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next = num;
            den_next = den;
            rem_next = '0;
            quo_next = '0;
            mod_next = '0;
            cnt_next = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            num_next  = {num_reg[NUM_W-2:0], 1'b0};
            rem_next  = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_next  = {quo_reg[Q_W-2:0], ge};
            mod_next  = mod_step;
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        mod_reg <= mod_next;
    end

    assign done    = done_reg;
    assign quo     = quo_reg;
    assign quo_mod = mod_reg;

endmodule

FILE: rtl/core/slmb_dp.sv
// ----------------------------------------------------------------------------
// slmb_dp
// Datapath: config registers, mode and phase state, shared divider,
// active-level multiply, color mapping and result register.
// ----------------------------------------------------------------------------
module slmb_dp #(
    parameter int WAVE_STEPS = slmb_pkg::WAVE_STEPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [slmb_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [slmb_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [slmb_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  slmb_pkg::slmb_cmd_t                cmd,
    output logic                               div_done,
    output logic [slmb_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    import slmb_pkg::*;

    localparam int IDX_W = $clog2(WAVE_STEPS);
    localparam int NUM_W = PHASE_W + IDX_W;

    // config registers
    logic [LEVEL_W-1:0]  rate_limit_reg;
    logic [LEVEL_W-1:0]  busy_thr_reg;
    logic [LEVEL_W-1:0]  act_min_reg;
    logic [LEVEL_W-1:0]  act_max_reg;
    logic [PERIOD_W-1:0] breathe_per_reg;
    logic [PERIOD_W-1:0] pulse_per_reg;

    // item state
    mode_t               mode_reg, mode_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [LEVEL_W-1:0]  act_reg;
    logic signed [17:0]  prod_reg;
    logic [OUT_TDATA_W-1:0] out_reg, out_next;

    // request fields
    logic                link_up;
    logic                usage_known;
    logic [LEVEL_W-1:0]  usage_pct;
    logic [LEVEL_W-1:0]  active_count;
    logic [PERIOD_W-1:0] tick_ms;

    logic [PHASE_W-1:0]  phase_base;
    logic [PHASE_W-1:0]  phase_sum;

    // divider operands and results
    logic [NUM_W-1:0]    div_num;
    logic [PERIOD_W-1:0] div_den;
    logic [PERIOD_W-1:0] period_sel;
    logic [LEVEL_W-1:0]  div_quo;
    logic [IDX_W-1:0]    div_mod;
    logic [LEVEL_W:0]    diff;
    logic                diff_neg;
    logic [LEVEL_W-1:0]  diff_mag;

    logic signed [LEVEL_W:0] step_s;
    logic [LEVEL_W-1:0]  act_m1;
    logic signed [18:0]  bright_s;
    logic [LEVEL_W-1:0]  green_act;

    logic [IDX_W+3:0]    idx_x16;
    logic [3:0]          wave_t;
    logic [LEVEL_W-1:0]  wave_lvl;
    logic [LEVEL_W-1:0]  red_lvl, green_lvl, blue_lvl;

    assign link_up      = s_tdata[0];
    assign usage_known  = s_tdata[1];
    assign usage_pct    = s_tdata[9:2];
    assign active_count = s_tdata[17:10];
    assign tick_ms      = s_tdata[33:18];

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_limit_reg  <= RATE_LIMIT_RST;
            busy_thr_reg    <= BUSY_THR_RST;
            act_min_reg     <= ACT_MIN_RST;
            act_max_reg     <= ACT_MAX_RST;
            breathe_per_reg <= BREATHE_PER_RST;
            pulse_per_reg   <= PULSE_PER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_RATE_LIMIT:  rate_limit_reg  <= cfg_data[LEVEL_W-1:0];
                REG_BUSY_THR:    busy_thr_reg    <= cfg_data[LEVEL_W-1:0];
                REG_ACT_MIN:     act_min_reg     <= cfg_data[LEVEL_W-1:0];
                REG_ACT_MAX:     act_max_reg     <= cfg_data[LEVEL_W-1:0];
                REG_BREATHE_PER: breathe_per_reg <= cfg_data;
                REG_PULSE_PER:   pulse_per_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ---------------- mode pick and phase advance ----------------
    always_comb
    begin
        if (!link_up)
        begin
            mode_next = MODE_OFF;
        end
        else if (usage_known && (usage_pct >= rate_limit_reg))
        begin
            mode_next = MODE_RATE;
        end
        else if (active_count >= busy_thr_reg)
        begin
            mode_next = MODE_BUSY;
        end
        else if (active_count != '0)
        begin
            mode_next = MODE_ACTIVE;
        end
        else
        begin
            mode_next = MODE_IDLE;
        end

        phase_base = (mode_next != mode_reg) ? '0 : phase_reg;
        phase_sum  = phase_base + PHASE_W'(tick_ms);
        if (phase_sum > PHASE_WRAP)
        begin
            phase_next = phase_sum - PHASE_WRAP;
        end
        else
        begin
            phase_next = phase_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_OFF;
            phase_reg <= '0;
        end
        else if (cmd.take)
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
        end
    end

    // ---------------- divider operands ----------------
    always_comb
    begin
        diff     = {1'b0, act_max_reg} - {1'b0, act_min_reg};
        diff_neg = diff[LEVEL_W];
        diff_mag = diff_neg ? LEVEL_W'(-diff) : diff[LEVEL_W-1:0];

        period_sel = (mode_reg == MODE_RATE) ? pulse_per_reg : breathe_per_reg;

        if (mode_reg == MODE_ACTIVE)
        begin
            div_num = NUM_W'(diff_mag);
            // threshold below two acts as divisor one
            if (busy_thr_reg < 8'd2)
            begin
                div_den = PERIOD_W'(1);
            end
            else
            begin
                div_den = PERIOD_W'(busy_thr_reg - 8'd1);
            end
        end
        else
        begin
            div_num = NUM_W'(phase_reg) * NUM_W'(WAVE_STEPS);
            div_den = (period_sel == '0) ? PERIOD_W'(1) : period_sel;
        end
    end

    slmb_div #(
        .NUM_W (NUM_W),
        .DEN_W (PERIOD_W),
        .Q_W   (LEVEL_W),
        .MOD_N (WAVE_STEPS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo),
        .quo_mod (div_mod)
    );

    // ---------------- active green level ----------------
    always_comb
    begin
        step_s = diff_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        act_m1 = act_reg - 8'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            act_reg <= active_count;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= $signed({1'b0, act_m1}) * step_s;
        end
    end

    always_comb
    begin
        bright_s = $signed({11'b0, act_min_reg}) + $signed({prod_reg[17], prod_reg});
        if (bright_s > $signed({11'b0, act_max_reg}))
        begin
            green_act = act_max_reg;
        end
        else if (bright_s < 0)
        begin
            green_act = '0;
        end
        else
        begin
            green_act = bright_s[LEVEL_W-1:0];
        end
    end

    // ---------------- breathing level and color map ----------------
    always_comb
    begin
        idx_x16  = {div_mod, 4'b0000};
        wave_t   = 4'(idx_x16 / WAVE_STEPS);
        wave_lvl = sine_level(wave_t);

        red_lvl   = '0;
        green_lvl = '0;
        blue_lvl  = '0;
        case (mode_reg)
            MODE_IDLE:
            begin
                green_lvl = {2'b00, wave_lvl[LEVEL_W-1:2]};
                blue_lvl  = div3(wave_lvl);
            end
            MODE_ACTIVE:
            begin
                green_lvl = green_act;
            end
            MODE_BUSY:
            begin
                red_lvl   = BUSY_RED;
                green_lvl = BUSY_GREEN;
            end
            MODE_RATE:
            begin
                red_lvl = wave_lvl;
            end
            default:
            begin
                red_lvl = '0;
            end
        endcase

        // active-low duties: 255 - level
        out_next = {5'b00000, ~blue_lvl, ~green_lvl, ~red_lvl, mode_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tdata = out_reg;

endmodule

FILE: rtl/core/slmb_ctrl.sv
// ----------------------------------------------------------------------------
// slmb_ctrl
// Sequencer: take request, start divider, multiply, load result register.
// Owns the output valid flag.
// ----------------------------------------------------------------------------
module slmb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 div_done,
    output slmb_pkg::slmb_cmd_t  cmd
);

    import slmb_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        s_tready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            ST_LOAD:
            begin
                cmd.div_start = 1'b1;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
            end
            ST_FIN:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

FILE: rtl/core/status_led_mode_breather.sv
// ----------------------------------------------------------------------------
// status_led_mode_breather
// Picks the status LED mode from each tick and drives active-low RGB duties.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  s_*       in    s_tvalid/s_tready    s_tdata: link, usage, workers, tick
//  m_*       out   m_tvalid/m_tready    m_tdata: mode, red/green/blue duty
//  cfg_*     in    cfg_valid/cfg_ready  cfg_addr register index, cfg_data
//
//  The divider works on NUM_W = 21 + clog2(WAVE_STEPS) numerator bits, one
//  quotient bit a cycle; a request passes ST_LOAD, ST_DIV, ST_MUL and ST_FIN.
//  A new request is taken only once the last result is loaded.
//  Reset is asynchronous; no clearing pass, ready accepts right after reset.
//  A finished result waits in the output register while the next request is
//  taken; the load stalls only if that register is full. Config always taken.
// ----------------------------------------------------------------------------
`include "status_led_mode_breather_defines.svh"

module status_led_mode_breather #(
    parameter int WAVE_STEPS = slmb_pkg::WAVE_STEPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [0] link_up, [1] usage_known, [9:2] usage_pct, [17:10] active_count,
    // [33:18] tick_ms, [39:34] zero
    input  logic [slmb_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [2:0] mode_code, [10:3] red_duty, [18:11] green_duty,
    // [26:19] blue_duty, [31:27] zero
    output logic [slmb_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [slmb_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [slmb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import slmb_pkg::*;

    slmb_cmd_t cmd;
    logic      div_done;
    logic      amber_ok;

    assign cfg_ready = 1'b1;

    slmb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .div_done (div_done),
        .cmd      (cmd)
    );

    slmb_dp #(
        .WAVE_STEPS (WAVE_STEPS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .div_done (div_done),
        .m_tdata  (m_tdata)
    );

    assign amber_ok = (m_tdata[10:3] == ~BUSY_RED) && (m_tdata[18:11] == ~BUSY_GREEN)
                      && (m_tdata[26:19] == 8'hFF);

    // one tick at a time: the cycle after a take the input side is closed
    `SLMB_ASSERT_NEXT(a_closed_after_take, s_tvalid && s_tready, !s_tready)

    // off mode is dark on all three channels
    `SLMB_ASSERT_IMPL(a_off_dark, m_tvalid && (m_tdata[2:0] == MODE_OFF), m_tdata[26:3] == '1)

    // busy amber is fixed
    `SLMB_ASSERT_IMPL(a_busy_amber, m_tvalid && (m_tdata[2:0] == MODE_BUSY), amber_ok)

endmodule
